@@ rtl/etc_pkg.sv @@
// ----------------------------------------------------------------------------
// Edge timestamp capture package
// Shared constants, codes and types for the edge timestamp capture unit.
// ----------------------------------------------------------------------------
package etc_pkg;

  localparam int RING_DEPTH_DEF   = 16;
  localparam int NUM_CHANNELS_DEF = 2;

  localparam int TS_HI_W   = 32;
  localparam int TS_LO_W   = 16;
  localparam int TS_W      = TS_HI_W + TS_LO_W;
  localparam int PULSE_W   = 32;
  localparam int STATUS_W  = 3;
  localparam int OUT_SLOT_W = 4;

  typedef enum logic [1:0] {
    FN_OVERFLOW = 2'd0,
    FN_CAPTURE  = 2'd1,
    FN_READ     = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE   = 3'd0,
    ST_RISE10 = 3'd1,
    ST_RISE90 = 3'd2,
    ST_FALL90 = 3'd3,
    ST_FALL10 = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

@@ rtl/etc_state_ram.sv @@
// ----------------------------------------------------------------------------
// Channel state memory
// Synchronous memory with one registered read port and one write port. Each
// entry has a valid bit cleared at reset; an entry not yet written reads zero.
// ----------------------------------------------------------------------------
module etc_state_ram #(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int WIDTH = 39
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/etc_record_ram.sv @@
// ----------------------------------------------------------------------------
// Edge record memory
// Simple dual-port synchronous memory holding the captured timestamps, with
// a registered read port. Contents are undefined until written.
// ----------------------------------------------------------------------------
module etc_record_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/edge_timestamp_capture_unit.sv @@
// ----------------------------------------------------------------------------
// Edge timestamp capture unit
// Timestamps threshold comparator edges of several pulse channels and keeps
// them in a per-channel record ring.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on the rising edge where start is high and busy is
//   low. An overflow tick is absorbed in that same cycle and produces no
//   result, so ticks may arrive every cycle. Unused function codes and
//   channels beyond the configured count are dropped in the same way.
//   A capture or a read raises busy for one cycle while the channel state
//   memory and the record memory are read; the next edge writes the updated
//   state back and loads the result registers. The result appears on the out_
//   ports with out_valid for exactly one cycle, registered at the end of the
//   execute state, and busy is already low in that cycle. A capture or a read
//   is not taken while the previous one still executes, because of the
//   read-modify-write of the channel state memory.
//   The receiver cannot stall: every result must be taken while out_valid is
//   high. Reset clears the overflow word and marks every channel state entry
//   as empty, so pulse counts and last status read as zero; the record
//   memory is not cleared and an entry must be written before it is read.
// ----------------------------------------------------------------------------
module edge_timestamp_capture_unit #(
  parameter int RING_DEPTH   = etc_pkg::RING_DEPTH_DEF,
  parameter int NUM_CHANNELS = etc_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic        in_channel,
  input  logic        in_level_select,
  input  logic        in_pin_high,
  input  logic [15:0] in_capture_count,
  input  logic [3:0]  in_read_slot,
  input  logic        in_read_falling,
  output logic        out_valid,
  output logic        out_channel,
  output logic [3:0]  out_slot,
  output logic [2:0]  out_edge_status,
  output logic [31:0] out_pulse_total,
  output logic [47:0] out_timestamp,
  output logic        out_next_edge_falling,
  output logic        out_is_read_reply
);

  localparam int CH_AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SLOT_W    = $clog2(RING_DEPTH);
  localparam int SLOT_XW   = SLOT_W + etc_pkg::OUT_SLOT_W;
  localparam int REC_DEPTH = NUM_CHANNELS * RING_DEPTH * 4;
  localparam int REC_AW    = $clog2(REC_DEPTH);
  localparam int ST_W      = etc_pkg::PULSE_W + SLOT_W + etc_pkg::STATUS_W;
  localparam int RS_W      = 9;
  localparam int RS_STEPS  = 8;

  function automatic logic [REC_AW-1:0] rec_addr(input logic [CH_AW-1:0]  ch,
                                                 input logic [SLOT_W-1:0] sl,
                                                 input logic              lv,
                                                 input logic              fa);
    logic [REC_AW-1:0] row;
    row = REC_AW'(ch) * REC_AW'(RING_DEPTH) + REC_AW'(sl);
    return (row << 2) | REC_AW'({lv, fa});
  endfunction

  etc_pkg::state_t state_r, state_nxt;

  // Transaction fields held for the execute cycle.
  logic                        is_read_r;
  logic [CH_AW-1:0]            ch_r;
  logic                        lvl_r;
  logic                        rise_r;
  logic [etc_pkg::TS_LO_W-1:0] cnt_r;
  logic [SLOT_W-1:0]           rslot_r;
  logic [etc_pkg::TS_HI_W-1:0] ovf_r, ovf_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [CH_AW-1:0]            out_ch_r;
  logic [3:0]                  out_slot_r, out_slot_nxt;
  logic [2:0]                  out_status_r, out_status_nxt;
  logic [31:0]                 out_pulse_r, out_pulse_nxt;
  logic [47:0]                 out_ts_r, out_ts_nxt;
  logic                        out_nef_r, out_nef_nxt;
  logic                        out_rd_r;

  logic                        accept;
  logic                        take_item;
  logic                        ch_ok;
  logic [CH_AW-1:0]            in_ch_idx;
  logic [RS_W-1:0]             rs_tmp;
  logic [SLOT_W-1:0]           rslot_red;

  logic [ST_W-1:0]             st_rdata;
  logic [ST_W-1:0]             st_wdata;
  logic                        st_we;
  logic [etc_pkg::PULSE_W-1:0] st_pulse, new_pulse;
  logic [SLOT_W-1:0]           st_slot, new_slot;
  logic [2:0]                  st_status;
  etc_pkg::status_t            new_status;

  logic [etc_pkg::TS_W-1:0]    rec_rdata;
  logic [etc_pkg::TS_W-1:0]    cap_ts;
  logic                        rec_we;
  logic [REC_AW-1:0]           rec_waddr;
  logic [REC_AW-1:0]           rec_raddr;
  logic [SLOT_XW-1:0]          slot_wide;

  assign busy   = (state_r == etc_pkg::S_EXEC);
  assign accept = start && !busy;
  assign ch_ok  = 32'(in_channel) < 32'(NUM_CHANNELS);
  assign in_ch_idx = CH_AW'(in_channel);

  // Read slot modulo the ring depth by repeated subtraction on a narrow value.
  always_comb begin
    rs_tmp = RS_W'(in_read_slot);
    for (int i = 0; i < RS_STEPS; i++) begin
      if (rs_tmp >= RS_W'(RING_DEPTH)) begin
        rs_tmp = rs_tmp - RS_W'(RING_DEPTH);
      end
    end
    rslot_red = SLOT_W'(rs_tmp);
  end

  assign rec_raddr = rec_addr(in_ch_idx, rslot_red, in_level_select, in_read_falling);

  // Accept-cycle decode and overflow word.
  always_comb begin
    take_item = 1'b0;
    ovf_nxt   = ovf_r;
    if (accept) begin
      unique case (in_func)
        etc_pkg::FN_OVERFLOW: ovf_nxt = ovf_r + etc_pkg::TS_HI_W'(1);
        etc_pkg::FN_CAPTURE,
        etc_pkg::FN_READ:     take_item = ch_ok;
        default:              take_item = 1'b0;
      endcase
    end
  end

  assign st_pulse  = st_rdata[ST_W-1 -: etc_pkg::PULSE_W];
  assign st_slot   = st_rdata[etc_pkg::STATUS_W +: SLOT_W];
  assign st_status = st_rdata[etc_pkg::STATUS_W-1:0];
  assign cap_ts    = {ovf_r, cnt_r};
  assign rec_waddr = rec_addr(ch_r, st_slot, lvl_r, !rise_r);

  // Next state, state write-back and result formation.
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    st_we          = 1'b0;
    rec_we         = 1'b0;
    new_pulse      = st_pulse;
    new_slot       = st_slot;
    new_status     = etc_pkg::ST_NONE;
    slot_wide      = SLOT_XW'(rslot_r);
    out_status_nxt = st_status;
    out_pulse_nxt  = st_pulse;
    out_ts_nxt     = rec_rdata;
    out_nef_nxt    = 1'b0;
    out_slot_nxt   = slot_wide[3:0];
    unique case (state_r)
      etc_pkg::S_IDLE: begin
        if (take_item) begin
          state_nxt = etc_pkg::S_EXEC;
        end
      end
      etc_pkg::S_EXEC: begin
        state_nxt     = etc_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
        if (!is_read_r) begin
          st_we  = 1'b1;
          rec_we = 1'b1;
          if (rise_r) begin
            new_status = lvl_r ? etc_pkg::ST_RISE90 : etc_pkg::ST_RISE10;
          end else if (lvl_r) begin
            new_status = etc_pkg::ST_FALL90;
          end else begin
            // A falling 10% edge completes the pulse and moves the ring on.
            new_status = etc_pkg::ST_FALL10;
            new_pulse  = st_pulse + etc_pkg::PULSE_W'(1);
            new_slot   = (st_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : st_slot + SLOT_W'(1);
          end
          slot_wide      = SLOT_XW'(st_slot);
          out_slot_nxt   = slot_wide[3:0];
          out_status_nxt = new_status;
          out_pulse_nxt  = new_pulse;
          out_ts_nxt     = cap_ts;
          out_nef_nxt    = rise_r;
        end
      end
      default: state_nxt = etc_pkg::S_IDLE;
    endcase
  end

  assign st_wdata = {new_pulse, new_slot, new_status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= etc_pkg::S_IDLE;
      ovf_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      is_read_r <= (in_func == etc_pkg::FN_READ);
      ch_r      <= in_ch_idx;
      lvl_r     <= in_level_select;
      rise_r    <= in_pin_high;
      cnt_r     <= in_capture_count;
      rslot_r   <= rslot_red;
    end
    if (state_r == etc_pkg::S_EXEC) begin
      out_ch_r     <= ch_r;
      out_slot_r   <= out_slot_nxt;
      out_status_r <= out_status_nxt;
      out_pulse_r  <= out_pulse_nxt;
      out_ts_r     <= out_ts_nxt;
      out_nef_r    <= out_nef_nxt;
      out_rd_r     <= is_read_r;
    end
  end

  etc_state_ram #(
    .DEPTH (NUM_CHANNELS),
    .AW    (CH_AW),
    .WIDTH (ST_W)
  ) u_state_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (take_item),
    .rd_addr (in_ch_idx),
    .rd_data (st_rdata),
    .wr_en   (st_we),
    .wr_addr (ch_r),
    .wr_data (st_wdata)
  );

  etc_record_ram #(
    .DEPTH (REC_DEPTH),
    .AW    (REC_AW),
    .WIDTH (etc_pkg::TS_W)
  ) u_record_ram (
    .clk     (clk),
    .rd_en   (take_item),
    .rd_addr (rec_raddr),
    .rd_data (rec_rdata),
    .wr_en   (rec_we),
    .wr_addr (rec_waddr),
    .wr_data (cap_ts)
  );

  assign out_valid             = out_valid_r;
  assign out_channel           = out_ch_r[0];
  assign out_slot              = out_slot_r;
  assign out_edge_status       = out_status_r;
  assign out_pulse_total       = out_pulse_r;
  assign out_timestamp         = out_ts_r;
  assign out_next_edge_falling = out_nef_r;
  assign out_is_read_reply     = out_rd_r;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Edge timestamp capture unit testbench
// Drives overflow ticks, comparator captures and record reads into the unit.
// Each accepted transaction is run through a local copy of the timebase,
// pulse counters and record ring. Every result strobe is checked field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] FN_UNUSED     = 2'd3;
  localparam int         RANDOM_ITEMS  = 1450;
  localparam int         DRAIN_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = 8;

  typedef struct packed {
    logic             channel;
    logic [3:0]       slot;
    etc_pkg::status_t status;
    logic [31:0]      pulses;
    logic [47:0]      stamp;
    logic             next_falling;
    logic             is_read;
  } edge_result_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic [1:0]  in_func         = '0;
  logic        in_channel      = 1'b0;
  logic        in_level_select = 1'b0;
  logic        in_pin_high     = 1'b0;
  logic [15:0] in_capture_count = '0;
  logic [3:0]  in_read_slot    = '0;
  logic        in_read_falling = 1'b0;

  logic        busy;
  logic        out_valid;
  logic        out_channel;
  logic [3:0]  out_slot;
  logic [2:0]  out_edge_status;
  logic [31:0] out_pulse_total;
  logic [47:0] out_timestamp;
  logic        out_next_edge_falling;
  logic        out_is_read_reply;

  // Local copy of the unit's state. Ring entries are keyed by
  // {channel, slot, comparator, falling}.
  logic [31:0]      hi_word = '0;
  logic [31:0]      pulses [2] = '{default: '0};
  etc_pkg::status_t last_edge [2] = '{default: etc_pkg::ST_NONE};
  logic [47:0]      ring_stamp [128];
  bit               ring_written [128] = '{default: 1'b0};
  logic [6:0]       stored_keys [$];

  edge_result_t owed_results [$];

  int mismatches = 0;
  int n_checked  = 0;
  int items_done = 0;
  int n_capture  = 0;
  int n_read     = 0;
  int n_tick     = 0;
  int n_ignored  = 0;
  bit steady_run = 1'b0;

  edge_timestamp_capture_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_func              (in_func),
    .in_channel           (in_channel),
    .in_level_select      (in_level_select),
    .in_pin_high          (in_pin_high),
    .in_capture_count     (in_capture_count),
    .in_read_slot         (in_read_slot),
    .in_read_falling      (in_read_falling),
    .out_valid            (out_valid),
    .out_channel          (out_channel),
    .out_slot             (out_slot),
    .out_edge_status      (out_edge_status),
    .out_pulse_total      (out_pulse_total),
    .out_timestamp        (out_timestamp),
    .out_next_edge_falling(out_next_edge_falling),
    .out_is_read_reply    (out_is_read_reply)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Advances the local state by one accepted transaction and queues the
  // result that it owes, if any.
  task automatic track_edge_item(input logic [1:0] f, input logic ch, input logic lvl,
                                 input logic pin, input logic [15:0] cnt,
                                 input logic [3:0] rslot, input logic rfall);
    edge_result_t     r;
    logic [6:0]       key;
    etc_pkg::status_t st;
    case (f)
      etc_pkg::FN_OVERFLOW: begin
        hi_word = hi_word + 32'd1;
        n_tick++;
      end
      etc_pkg::FN_CAPTURE: begin
        key = {ch, pulses[ch][3:0], lvl, ~pin};
        ring_stamp[key] = {hi_word, cnt};
        if (!ring_written[key]) begin
          ring_written[key] = 1'b1;
          stored_keys.push_back(key);
        end
        if (pin) st = lvl ? etc_pkg::ST_RISE90 : etc_pkg::ST_RISE10;
        else     st = lvl ? etc_pkg::ST_FALL90 : etc_pkg::ST_FALL10;
        r.channel = ch;
        r.slot    = pulses[ch][3:0];
        // Only the falling edge at the low threshold completes a pulse.
        if (st == etc_pkg::ST_FALL10) pulses[ch] = pulses[ch] + 32'd1;
        last_edge[ch]  = st;
        r.status       = st;
        r.pulses       = pulses[ch];
        r.stamp        = {hi_word, cnt};
        r.next_falling = pin;
        r.is_read      = 1'b0;
        owed_results.push_back(r);
        n_capture++;
      end
      etc_pkg::FN_READ: begin
        key            = {ch, rslot, lvl, rfall};
        r.channel      = ch;
        r.slot         = rslot;
        r.status       = last_edge[ch];
        r.pulses       = pulses[ch];
        r.stamp        = ring_stamp[key];
        r.next_falling = 1'b0;
        r.is_read      = 1'b1;
        owed_results.push_back(r);
        n_read++;
      end
      default: n_ignored++;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (steady_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Presents one transaction, holds it until the unit takes it, then idles
  // for a random gap.
  task automatic issue_item(input logic [1:0] f, input logic ch, input logic lvl,
                            input logic pin, input logic [15:0] cnt,
                            input logic [3:0] rslot, input logic rfall);
    int gap;
    in_func          <= f;
    in_channel       <= ch;
    in_level_select  <= lvl;
    in_pin_high      <= pin;
    in_capture_count <= cnt;
    in_read_slot     <= rslot;
    in_read_falling  <= rfall;
    start            <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    track_edge_item(f, ch, lvl, pin, cnt, rslot, rfall);
    if (f != FN_UNUSED) items_done++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic tick();
    issue_item(etc_pkg::FN_OVERFLOW, 1'($urandom), 1'($urandom), 1'($urandom),
               16'($urandom), 4'($urandom), 1'($urandom));
  endtask

  task automatic capture(input logic ch, input logic lvl, input logic pin,
                         input logic [15:0] cnt);
    issue_item(etc_pkg::FN_CAPTURE, ch, lvl, pin, cnt, 4'($urandom), 1'($urandom));
  endtask

  task automatic read_back(input logic ch, input logic [3:0] slot, input logic lvl,
                           input logic rfall);
    issue_item(etc_pkg::FN_READ, ch, lvl, 1'($urandom), 16'($urandom), slot, rfall);
  endtask

  // Reads only entries that have been written at least once.
  task automatic read_stored();
    logic [6:0] key;
    if (stored_keys.size() == 0) return;
    key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    read_back(key[6], key[5:2], key[1], key[0]);
  endtask

  // One pulse: rise at 10%, rise at 90%, fall at 90%, fall at 10%, with the
  // occasional tick between edges. Now and then an edge is dropped or
  // replaced to break the sequence.
  task automatic run_pulse(input logic ch);
    logic        lvl_seq [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
    logic        pin_seq [4] = '{1'b1, 1'b1, 1'b0, 1'b0};
    logic [15:0] cnt;
    int          mode;
    cnt = 16'($urandom);
    for (int i = 0; i < 4; i++) begin
      mode = $urandom_range(0, 19);
      if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 2)) tick();
      cnt = cnt + 16'($urandom_range(1, 3000));
      if (mode == 0) continue;
      if (mode == 1) capture(ch, 1'($urandom), 1'($urandom), cnt);
      else capture(ch, lvl_seq[i], pin_seq[i], cnt);
    end
  endtask

  always @(posedge clk) begin : result_check
    edge_result_t want;
    if (rst_n && out_valid) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result: channel %0d slot %0d status %0d", out_channel, out_slot,
               out_edge_status);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        n_checked++;
        if (out_channel !== want.channel) begin
          $error("out_channel: expected %0d, got %0d", want.channel, out_channel);
          mismatches++;
        end
        if (out_slot !== want.slot) begin
          $error("out_slot: expected %0d, got %0d", want.slot, out_slot);
          mismatches++;
        end
        if (out_edge_status !== want.status) begin
          $error("out_edge_status: expected %0d, got %0d", want.status, out_edge_status);
          mismatches++;
        end
        if (out_pulse_total !== want.pulses) begin
          $error("out_pulse_total: expected %0d, got %0d", want.pulses, out_pulse_total);
          mismatches++;
        end
        if (out_timestamp !== want.stamp) begin
          $error("out_timestamp: expected %h, got %h", want.stamp, out_timestamp);
          mismatches++;
        end
        if (out_next_edge_falling !== want.next_falling) begin
          $error("out_next_edge_falling: expected %0d, got %0d", want.next_falling,
                 out_next_edge_falling);
          mismatches++;
        end
        if (out_is_read_reply !== want.is_read) begin
          $error("out_is_read_reply: expected %0d, got %0d", want.is_read,
                 out_is_read_reply);
          mismatches++;
        end
      end
    end
  end

  // A complete pulse on channel 0 with the count at both ends of its range.
  task automatic test_single_pulse();
    capture(1'b0, 1'b0, 1'b1, 16'h0000);
    capture(1'b0, 1'b1, 1'b1, 16'h1234);
    capture(1'b0, 1'b1, 1'b0, 16'hA5A5);
    capture(1'b0, 1'b0, 1'b0, 16'hFFFF);
  endtask

  // Ticks must show up in the high word of later timestamps.
  task automatic test_overflow_ticks();
    tick();
    tick();
    capture(1'b1, 1'b0, 1'b1, 16'hFFFF);
    capture(1'b1, 1'b0, 1'b0, 16'h0000);
  endtask

  // The spare function code must leave every piece of state alone.
  task automatic test_unused_code();
    issue_item(FN_UNUSED, 1'b1, 1'b1, 1'b1, 16'hFFFF, 4'hF, 1'b1);
    issue_item(FN_UNUSED, 1'b0, 1'b0, 1'b0, 16'h0000, 4'h0, 1'b0);
    tick();
    read_back(1'b1, 4'd0, 1'b0, 1'b0);
  endtask

  // All four channel 0 entries written so far and one channel 1 entry, plus a capture into the advanced slot.
  task automatic test_readback();
    read_back(1'b0, 4'd0, 1'b0, 1'b0);
    read_back(1'b0, 4'd0, 1'b1, 1'b0);
    read_back(1'b0, 4'd0, 1'b1, 1'b1);
    read_back(1'b0, 4'd0, 1'b0, 1'b1);
    read_back(1'b1, 4'd0, 1'b0, 1'b1);
    capture(1'b0, 1'b0, 1'b1, 16'h8000);
    read_back(1'b0, 4'd1, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int target;
    int r;
    target = items_done + RANDOM_ITEMS;
    while (items_done < target) begin
      steady_run = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) run_pulse(1'($urandom));
      else if (r < 80) repeat ($urandom_range(1, 4)) read_stored();
      else if (r < 90) repeat ($urandom_range(1, 5)) tick();
      else if (r < 95) capture(1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
      else issue_item(FN_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom),
                      16'($urandom), 4'($urandom), 1'($urandom));
      steady_run = 1'b0;
    end
  endtask

  initial begin
    int waited;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_single_pulse();
    test_overflow_ticks();
    test_unused_code();
    test_readback();
    test_random_traffic();

    start <= 1'b0;
    waited = 0;
    while (owed_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      mismatches++;
    end

    $display("Covered %0d captures, %0d reads, %0d ticks and %0d dropped transactions.",
             n_capture, n_read, n_tick, n_ignored);
    $display("Checked %0d results; pulses completed: channel 0 %0d, channel 1 %0d.",
             n_checked, pulses[0], pulses[1]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
